>>> rtl/assert_macros.svh
// Assertion helpers for the message ring FIFO.
// Both macros check on the rising edge of the given clock, off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Condition must never be true at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

	// ring geometry
	localparam int SLOTS      = 16;
	localparam int SLOT_BYTES = 2048;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int OFF_W      = $clog2(SLOT_BYTES);
	localparam int ADDR_W     = SLOT_W + OFF_W;
	localparam int CNT_W      = 12;
	localparam int DEPTH      = SLOTS * SLOT_BYTES;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_TOOLONG = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	// request kinds
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef logic [SLOT_W-1:0] slot_t;

	// byte memory write and read requests
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// next slot around the ring
	function automatic slot_t slot_inc(input slot_t s);
		slot_inc = (s == slot_t'(SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
	endfunction

endpackage

`default_nettype wire

>>> rtl/message_ring_fifo.sv
// Message ring FIFO: 16 slots of up to 2048 bytes; one slot stays free, so 15
// messages fit. All requests enter on the s_ channel, one byte per request.
// Push (s_tuser[0]=0): s_tdata[7:0] is the byte, s_tlast ends the message,
// s_tuser[1] marks a zero-length message. Room is checked at the first byte;
// a message longer than a slot is reported too long. Only the final push
// request gives a result, carrying the status and accepted length.
// Pop (s_tuser[0]=1): each request returns at most one byte, truncated to the
// receiver capacity in s_tdata[19:8]; the final byte has m_tlast set and
// the delivered length. Popping an empty queue returns status empty.
// A result passes the staging stage (synchronous byte memory read) and
// then the output register before it appears on m_.
// Throughput: one request per cycle while s_tready is high; the
// single-port read of the byte memory and the result stage set that figure.
// Reset empties the ring and clears any partial push or pop; memory
// contents are not cleared and need no clearing pass.
// When m_tready is low, results wait in the output and staging registers;
// s_tready drops once both are full, and nothing is lost.
`default_nettype none

module message_ring_fifo (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [7:0] data_byte, [19:8] receiver_capacity, [23:20] zero
	input  wire         s_tlast,   // last
	input  wire  [1:0]  s_tuser,   // [0] command, [1] no_data
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [19:8] length, [23:20] zero
	output logic        m_tlast,   // end_of_message
	output logic [2:0]  m_tuser    // [1:0] status, [2] has_data
);
	import mrf_pkg::*;

	`include "assert_macros.svh"

	// ring state
	slot_t            write_slot_q, write_slot_d;
	slot_t            read_slot_q, read_slot_d;
	logic [CNT_W-1:0] push_count_q, push_count_d;
	logic [1:0]       push_reject_q, push_reject_d;
	logic [CNT_W-1:0] pop_offset_q, pop_offset_d;
	logic [CNT_W-1:0] slot_len_q [SLOTS];

	// request fields
	logic             accept;
	logic             cmd;
	logic [7:0]       in_byte;
	logic             in_last;
	logic             in_nodata;
	logic [CNT_W-1:0] in_cap;

	// working values
	logic [CNT_W-1:0] cnt_c;
	logic [1:0]       rej_c;
	logic [CNT_W-1:0] cap_c;
	logic [CNT_W-1:0] deliver_c;
	logic [CNT_W-1:0] off_inc_c;
	logic             len_we;
	logic             commit_c;
	ram_wr_t          wr_req;
	ram_rd_t          rd_req;
	logic [7:0]       rd_data;

	// result of the current request
	logic             res_fire;
	logic [1:0]       res_status;
	logic             res_has_data;
	logic             res_eom;
	logic [CNT_W-1:0] res_len;

	// staging stage (memory read in flight) and output register
	logic             valid_s1;
	logic [1:0]       status_s1;
	logic             has_data_s1;
	logic             eom_s1;
	logic [CNT_W-1:0] length_s1;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [7:0]       out_byte_q;
	logic             out_has_data_q;
	logic             out_eom_q;
	logic [CNT_W-1:0] out_len_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	assign cmd       = s_tuser[0];
	assign in_nodata = s_tuser[1];
	assign in_byte   = s_tdata[7:0];
	assign in_cap    = s_tdata[19:8];
	assign in_last   = s_tlast;

	// clamp capacity, then truncate the stored length
	assign cap_c     = (in_cap > CNT_W'(SLOT_BYTES)) ? CNT_W'(SLOT_BYTES) : in_cap;
	assign deliver_c = (slot_len_q[read_slot_q] > cap_c) ? cap_c : slot_len_q[read_slot_q];
	assign off_inc_c = pop_offset_q + 1'b1;

	// request decode and state update
	always_comb begin
		write_slot_d  = write_slot_q;
		read_slot_d   = read_slot_q;
		push_count_d  = push_count_q;
		push_reject_d = push_reject_q;
		pop_offset_d  = pop_offset_q;
		cnt_c         = push_count_q;
		rej_c         = push_reject_q;
		len_we        = 1'b0;
		commit_c      = 1'b0;
		wr_req        = '0;
		rd_req        = '0;
		res_fire      = 1'b0;
		res_status    = ST_OK;
		res_has_data  = 1'b0;
		res_eom       = 1'b0;
		res_len       = '0;
		if (accept) begin
			if (cmd == CMD_PUSH) begin
				if (!(in_nodata && !in_last)) begin
					// room check at the first byte of a message
					if (cnt_c == '0 && rej_c == ST_OK && slot_inc(write_slot_q) == read_slot_q) begin
						rej_c = ST_FULL;
					end
					if (!in_nodata && rej_c != ST_TOOLONG) begin
						if (cnt_c >= CNT_W'(SLOT_BYTES)) begin
							rej_c = ST_TOOLONG;
						end else begin
							if (rej_c == ST_OK) begin
								wr_req.en   = 1'b1;
								wr_req.addr = {write_slot_q, cnt_c[OFF_W-1:0]};
								wr_req.data = in_byte;
							end
							cnt_c = cnt_c + 1'b1;
						end
					end
					if (in_last) begin
						res_fire   = 1'b1;
						res_status = rej_c;
						res_eom    = 1'b1;
						if (rej_c == ST_OK) begin
							res_len      = cnt_c;
							len_we       = 1'b1;
							commit_c     = 1'b1;
							write_slot_d = slot_inc(write_slot_q);
						end
						cnt_c = '0;
						rej_c = ST_OK;
					end
					push_count_d  = cnt_c;
					push_reject_d = rej_c;
				end
			end else begin
				res_fire = 1'b1;
				if (read_slot_q == write_slot_q) begin
					res_status = ST_EMPTY;
					res_eom    = 1'b1;
				end else if (pop_offset_q >= deliver_c) begin
					// capacity already reached: close the message without a byte
					res_eom      = 1'b1;
					res_len      = pop_offset_q;
					pop_offset_d = '0;
					read_slot_d  = slot_inc(read_slot_q);
				end else begin
					rd_req.en    = 1'b1;
					rd_req.addr  = {read_slot_q, pop_offset_q[OFF_W-1:0]};
					res_has_data = 1'b1;
					if (off_inc_c == deliver_c) begin
						res_eom      = 1'b1;
						res_len      = deliver_c;
						pop_offset_d = '0;
						read_slot_d  = slot_inc(read_slot_q);
					end else begin
						pop_offset_d = off_inc_c;
					end
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q  <= '0;
			read_slot_q   <= '0;
			push_count_q  <= '0;
			push_reject_q <= ST_OK;
			pop_offset_q  <= '0;
		end else begin
			write_slot_q  <= write_slot_d;
			read_slot_q   <= read_slot_d;
			push_count_q  <= push_count_d;
			push_reject_q <= push_reject_d;
			pop_offset_q  <= pop_offset_d;
		end
	end

	// message lengths, taken from the committed push result
	always_ff @(posedge clk) begin
		if (len_we) begin
			slot_len_q[write_slot_q] <= res_len;
		end
	end

	mrf_byte_ram u_ram (
		.clk     (clk),
		.wr      (wr_req),
		.rd      (rd_req),
		.rd_data (rd_data)
	);

	// staging stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= res_fire;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// staging stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= res_status;
			has_data_s1 <= res_has_data;
			eom_s1      <= res_eom;
			length_s1   <= res_len;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload, byte taken from the memory read
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_status_q   <= status_s1;
			out_byte_q     <= has_data_s1 ? rd_data : 8'd0;
			out_has_data_q <= has_data_s1;
			out_eom_q      <= eom_s1;
			out_len_q      <= length_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_len_q, out_byte_q};
	assign m_tlast  = out_eom_q;
	assign m_tuser  = {out_has_data_q, out_status_q};

	// checks
	`ASSERT_NEVER(a_count_range, clk, arst_n, push_count_q > CNT_W'(SLOT_BYTES))
	`ASSERT_NEVER(a_offset_range, clk, arst_n, pop_offset_q >= CNT_W'(SLOT_BYTES))
	`ASSERT_NEVER(a_reject_code, clk, arst_n, push_reject_q == ST_EMPTY)
	`ASSERT_NEVER(a_no_overrun, clk, arst_n, commit_c && (slot_inc(write_slot_q) == read_slot_q))
	`ASSERT_AT(a_stall_blocks, clk, arst_n, (valid_s1 && out_valid_q && !m_tready) |-> !s_tready)

endmodule

`default_nettype wire

>>> rtl/mrf_byte_ram.sv
`default_nettype none

// Message byte storage: one write port, one read port, registered read data.
module mrf_byte_ram (
	input  wire                   clk,
	input  mrf_pkg::ram_wr_t      wr,
	input  mrf_pkg::ram_rd_t      rd,
	output logic [7:0]            rd_data
);
	import mrf_pkg::*;

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire
